FILE: hw/rtl/assert_macros.svh
// Assertion macros for the files that check their own logic.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define QTE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QTE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/qte_pkg.sv
package qte_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int CORDIC_STEPS  = 16;
    localparam int WORK_BITS     = 30;
    localparam int TABLE_LEN     = 24;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;
    localparam int PROD_W        = 2 * IN_W;
    localparam int RAW_W         = (2 * FRACTION_BITS + 2 > 36) ? 2 * FRACTION_BITS + 2 : 36;
    localparam int TERM_MAG      = (2 * FRACTION_BITS < WORK_BITS) ?
                                   35 + WORK_BITS - 2 * FRACTION_BITS : 35;
    localparam int WW            = TERM_MAG + 4;
    localparam int SHL           = (2 * FRACTION_BITS < WORK_BITS) ?
                                   WORK_BITS - 2 * FRACTION_BITS : 0;
    localparam int SHR           = (2 * FRACTION_BITS >= WORK_BITS) ?
                                   2 * FRACTION_BITS - WORK_BITS : 0;
    localparam int ACC_W         = 28;
    localparam int STEP_W        = 5;
    localparam int SQ_W          = 2 * WORK_BITS + 2;
    localparam int SQRT_CELLS    = WORK_BITS + 1;
    localparam int S_W           = WORK_BITS + 2;

    localparam longint THR_LO    = 64'sd1063004406;
    localparam longint THR_HI    = 64'sd1084479242;
    localparam int     OUT_LIMIT = 23040;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [RAW_W-1:0]  t_raw;
    typedef logic signed [WW-1:0]     t_work;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_acc DEG180 = t_acc'(180 * 65536);

    typedef struct packed {
        t_work x;
        t_work y;
        t_acc  acc;
        logic  zero;
    } t_vec;

    typedef struct packed {
        logic [SQ_W-1:0]       rem;
        logic [SQ_W-1:0]       res;
        logic [SQ_W-1:0]       pw4;
        logic signed [S_W-1:0] s;
    } t_sq;

    typedef struct packed {
        logic signed [OUT_W-1:0] angle_x;
        logic signed [OUT_W-1:0] angle_y;
        logic signed [OUT_W-1:0] angle_z;
    } t_euler;

    typedef struct packed {
        logic pp;
        logic pn;
    } t_pole;

    // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
    function automatic t_acc atan_entry(input logic [STEP_W-1:0] i);
        t_acc v;
        case (i)
            5'd0:    v = t_acc'(2949120);
            5'd1:    v = t_acc'(1740967);
            5'd2:    v = t_acc'(919879);
            5'd3:    v = t_acc'(466945);
            5'd4:    v = t_acc'(234379);
            5'd5:    v = t_acc'(117304);
            5'd6:    v = t_acc'(58666);
            5'd7:    v = t_acc'(29335);
            5'd8:    v = t_acc'(14668);
            5'd9:    v = t_acc'(7334);
            5'd10:   v = t_acc'(3667);
            5'd11:   v = t_acc'(1833);
            5'd12:   v = t_acc'(917);
            5'd13:   v = t_acc'(458);
            5'd14:   v = t_acc'(229);
            5'd15:   v = t_acc'(115);
            5'd16:   v = t_acc'(57);
            5'd17:   v = t_acc'(29);
            5'd18:   v = t_acc'(14);
            5'd19:   v = t_acc'(7);
            5'd20:   v = t_acc'(4);
            5'd21:   v = t_acc'(2);
            5'd22:   v = t_acc'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Brings a term with 2*FRACTION_BITS fraction bits to WORK_BITS, flooring.
    function automatic t_work to_work(input t_raw v);
        t_raw sh;
        sh = v >>> SHR;
        return t_work'(sh) <<< SHL;
    endfunction

    // Folds the left half plane onto the right one before the rotations.
    function automatic t_vec cordic_prep(input t_work y, input t_work x);
        t_vec v;
        v.zero = (x == '0) && (y == '0);
        v.acc  = '0;
        v.x    = x;
        v.y    = y;
        if (x[WW-1]) begin
            v.acc = y[WW-1] ? -DEG180 : DEG180;
            v.x   = -x;
            v.y   = -y;
        end
        return v;
    endfunction

    // Rounds half up to 1/128 degree and clamps to +-180 degrees.
    function automatic logic signed [OUT_W-1:0] to_out(input t_acc a, input logic zero);
        t_acc r;
        r = (a + t_acc'(256)) >>> 9;
        if (zero) begin
            r = '0;
        end else if (r > t_acc'(OUT_LIMIT)) begin
            r = t_acc'(OUT_LIMIT);
        end else if (r < t_acc'(-OUT_LIMIT)) begin
            r = t_acc'(-OUT_LIMIT);
        end
        return OUT_W'(r);
    endfunction

endpackage

FILE: hw/rtl/qte_quat_if.sv
interface qte_quat_if;
    import qte_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] q_w;
    logic signed [IN_W-1:0] q_x;
    logic signed [IN_W-1:0] q_y;
    logic signed [IN_W-1:0] q_z;
    modport source (output valid, q_w, q_x, q_y, q_z, input ready);
    modport sink   (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

FILE: hw/rtl/qte_euler_if.sv
interface qte_euler_if;
    import qte_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] angle_x;
    logic signed [OUT_W-1:0] angle_y;
    logic signed [OUT_W-1:0] angle_z;
    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

FILE: hw/rtl/qte_sqrt_cell.sv
module qte_sqrt_cell (
    input  logic        i_clk,
    input  logic        i_en,
    input  qte_pkg::t_sq i_d,
    output qte_pkg::t_sq o_d
);
    import qte_pkg::*;

    logic [SQ_W:0] w_t;
    t_sq           n_d;
    t_sq           r_d;

    // One result bit per cell: subtract the trial value when it fits.
    always_comb begin
        w_t = {1'b0, i_d.res} + {1'b0, i_d.pw4};
        n_d = i_d;
        if ({1'b0, i_d.rem} >= w_t) begin
            n_d.rem = i_d.rem - w_t[SQ_W-1:0];
            n_d.res = (i_d.res >> 1) + i_d.pw4;
        end else begin
            n_d.res = i_d.res >> 1;
        end
        n_d.pw4 = i_d.pw4 >> 2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

FILE: hw/rtl/qte_cordic_cell.sv
module qte_cordic_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [qte_pkg::STEP_W-1:0] i_step,
    input  qte_pkg::t_vec              i_d,
    output qte_pkg::t_vec              o_d
);
    import qte_pkg::*;

    t_work w_dx;
    t_work w_dy;
    t_acc  w_a;
    t_vec  n_d;
    t_vec  r_d;

    // One vectoring rotation, driving y toward zero.
    always_comb begin
        w_dx = i_d.y >>> i_step;
        w_dy = i_d.x >>> i_step;
        w_a  = atan_entry(i_step);
        n_d  = i_d;
        if (!i_d.y[WW-1]) begin
            n_d.x   = i_d.x + w_dx;
            n_d.y   = i_d.y - w_dy;
            n_d.acc = i_d.acc + w_a;
        end else begin
            n_d.x   = i_d.x - w_dx;
            n_d.y   = i_d.y + w_dy;
            n_d.acc = i_d.acc - w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

FILE: hw/rtl/quaternion_to_euler_angles_unit.sv
// Quaternion to Euler angle converter.
// Input channel i_quat carries one unit quaternion per item (q_w, q_x, q_y, q_z,
// signed Q2.14). Output channel o_euler carries one item per input item with
// angle_x, angle_y, angle_z in signed units of 1/128 degree, in input order.
// Both channels move an item when valid and ready are high at a clock edge.
// The block is a fully pipelined chain of cells and takes one item every
// cycle unless it is stalled. After an item is accepted, three front
// stages form the products, the matrix terms and the pole decision, then the
// asin path runs through a squaring stage, 31 square-root cells (one bit of
// the root per cell), a fold stage, 16 CORDIC cells and a final output stage.
// The two atan2 paths run their CORDIC rows right away and wait in a delay
// line for the asin path. The output register stands apart from the last
// pipeline stage, so the pipeline keeps accepting items while a finished item
// waits, and stops only when both hold an item that the receiver has not
// taken. A synchronous active-low reset empties the pipeline and the output
// register; no item is lost or repeated across a stall.
`include "assert_macros.svh"
module quaternion_to_euler_angles_unit (
    input logic         i_clk,
    input logic         i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);
    import qte_pkg::*;

    // Stage indexes: 0 products, 1 matrix terms, 2 pole decision, then the
    // asin path up to the output stage LAT-1.
    localparam int LAT      = 6 + SQRT_CELLS + CORDIC_STEPS;
    localparam int POLE_LEN = SQRT_CELLS + CORDIC_STEPS + 3;

    typedef struct packed {
        logic signed [OUT_W-1:0] ay;
        logic signed [OUT_W-1:0] az;
    } t_yz;

    logic [LAT-1:0] r_vld;
    logic           w_en;
    logic           w_oload;
    logic           r_o_vld;
    t_euler         r_o;
    t_euler         r_p;
    t_euler         w_p;

    t_prod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_work r_m00, r_m01, r_m10, r_m11, r_m20, r_m21, r_m22;
    t_raw  w_one;

    t_work                 w_s_full;
    t_work                 w_unit;
    t_work                 w_s_clamp;
    logic signed [S_W-1:0] w_s_trunc;
    logic signed [S_W-1:0] w_s_abs;
    logic                  w_pp;
    logic                  w_pn;
    logic signed [S_W-1:0] r_s;
    logic [WORK_BITS:0]    r_sabs;
    t_work                 r_ya, r_yb, r_za, r_zb;
    t_pole                 r_pole [POLE_LEN];

    logic [SQ_W-1:0] w_sq_prod;
    t_sq             r_sq0;
    t_sq             w_sq [SQRT_CELLS+1];

    t_vec r_xv, r_yv, r_zv;
    t_vec w_xc [CORDIC_STEPS+1];
    t_vec w_yc [CORDIC_STEPS+1];
    t_vec w_zc [CORDIC_STEPS+1];
    t_yz  r_conv;
    t_yz  r_dly [SQRT_CELLS];

    // The pipeline moves unless the last stage and the output register both
    // hold items the receiver has not taken.
    assign w_oload      = !r_o_vld || o_euler.ready;
    assign w_en         = !r_vld[LAT-1] || w_oload;
    assign i_quat.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_quat.valid};
            end
            if (w_oload) begin
                r_o_vld <= r_vld[LAT-1];
            end
        end
    end

    // Stage 0: all nine products of the quaternion components.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xx <= t_prod'(i_quat.q_x) * t_prod'(i_quat.q_x);
            r_yy <= t_prod'(i_quat.q_y) * t_prod'(i_quat.q_y);
            r_zz <= t_prod'(i_quat.q_z) * t_prod'(i_quat.q_z);
            r_xy <= t_prod'(i_quat.q_x) * t_prod'(i_quat.q_y);
            r_xz <= t_prod'(i_quat.q_x) * t_prod'(i_quat.q_z);
            r_yz <= t_prod'(i_quat.q_y) * t_prod'(i_quat.q_z);
            r_wx <= t_prod'(i_quat.q_w) * t_prod'(i_quat.q_x);
            r_wy <= t_prod'(i_quat.q_w) * t_prod'(i_quat.q_y);
            r_wz <= t_prod'(i_quat.q_w) * t_prod'(i_quat.q_z);
        end
    end

    // Stage 1: the rotation matrix terms in the working format.
    assign w_one = t_raw'(1) <<< (2 * FRACTION_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m00 <= to_work(w_one - ((t_raw'(r_yy) + t_raw'(r_zz)) <<< 1));
            r_m01 <= to_work((t_raw'(r_xy) + t_raw'(r_wz)) <<< 1);
            r_m10 <= to_work((t_raw'(r_xy) - t_raw'(r_wz)) <<< 1);
            r_m11 <= to_work(w_one - ((t_raw'(r_xx) + t_raw'(r_zz)) <<< 1));
            r_m20 <= to_work((t_raw'(r_xz) + t_raw'(r_wy)) <<< 1);
            r_m21 <= to_work((t_raw'(r_yz) - t_raw'(r_wx)) <<< 1);
            r_m22 <= to_work(w_one - ((t_raw'(r_xx) + t_raw'(r_yy)) <<< 1));
        end
    end

    // Stage 2: pole decision, clamped asin argument and atan2 operands. Near
    // a pole the heading comes from the other pair of matrix terms.
    always_comb begin
        w_pp     = (r_m21 >= t_work'(THR_LO)) && (r_m21 <= t_work'(THR_HI));
        w_pn     = (r_m21 >= t_work'(-THR_HI)) && (r_m21 <= t_work'(-THR_LO));
        w_unit   = t_work'(1) <<< WORK_BITS;
        w_s_full = -r_m21;
        if (w_s_full > w_unit) begin
            w_s_clamp = w_unit;
        end else if (w_s_full < -w_unit) begin
            w_s_clamp = -w_unit;
        end else begin
            w_s_clamp = w_s_full;
        end
        w_s_trunc = S_W'(w_s_clamp);
        w_s_abs   = w_s_trunc[S_W-1] ? -w_s_trunc : w_s_trunc;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s       <= w_s_trunc;
            r_sabs    <= w_s_abs[WORK_BITS:0];
            r_pole[0] <= '{pp: w_pp, pn: w_pn};
            r_ya      <= r_m20;
            r_yb      <= r_m22;
            r_za      <= (w_pp || w_pn) ? r_m10 : r_m01;
            r_zb      <= (w_pp || w_pn) ? r_m00 : r_m11;
            for (int k = 1; k < POLE_LEN; k++) begin
                r_pole[k] <= r_pole[k-1];
            end
        end
    end

    // The asin path: c = sqrt(1 - s^2), one root bit per cell.
    assign w_sq_prod = SQ_W'(r_sabs) * SQ_W'(r_sabs);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq0.rem <= (SQ_W'(1) << (2 * WORK_BITS)) - w_sq_prod;
            r_sq0.res <= '0;
            r_sq0.pw4 <= SQ_W'(1) << (2 * WORK_BITS);
            r_sq0.s   <= r_s;
        end
    end

    assign w_sq[0] = r_sq0;

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sq[g]),
            .o_d   (w_sq[g+1])
        );
    end

    // Fold stages ahead of the three CORDIC rows.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xv <= cordic_prep(t_work'(w_sq[SQRT_CELLS].s),
                                t_work'({1'b0, w_sq[SQRT_CELLS].res[WORK_BITS:0]}));
            r_yv <= cordic_prep(r_ya, r_yb);
            r_zv <= cordic_prep(r_za, r_zb);
        end
    end

    assign w_xc[0] = r_xv;
    assign w_yc[0] = r_yv;
    assign w_zc[0] = r_zv;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        qte_cordic_cell u_x (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (STEP_W'(g)),
            .i_d    (w_xc[g]),
            .o_d    (w_xc[g+1])
        );
        qte_cordic_cell u_y (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (STEP_W'(g)),
            .i_d    (w_yc[g]),
            .o_d    (w_yc[g+1])
        );
        qte_cordic_cell u_z (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_step (STEP_W'(g)),
            .i_d    (w_zc[g]),
            .o_d    (w_zc[g+1])
        );
    end

    // The y and z angles wait here until the asin path catches up.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_conv.ay <= to_out(w_yc[CORDIC_STEPS].acc, w_yc[CORDIC_STEPS].zero);
            r_conv.az <= to_out(w_zc[CORDIC_STEPS].acc, w_zc[CORDIC_STEPS].zero);
            r_dly[0]  <= r_conv;
            for (int k = 1; k < SQRT_CELLS; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // Output stage: at a pole the pitch is fixed and the roll is zero.
    always_comb begin
        if (r_pole[POLE_LEN-1].pp) begin
            w_p.angle_x = OUT_W'(OUT_LIMIT);
        end else if (r_pole[POLE_LEN-1].pn) begin
            w_p.angle_x = OUT_W'(-OUT_LIMIT);
        end else begin
            w_p.angle_x = to_out(w_xc[CORDIC_STEPS].acc, w_xc[CORDIC_STEPS].zero);
        end
        w_p.angle_y = (r_pole[POLE_LEN-1].pp || r_pole[POLE_LEN-1].pn) ?
                      '0 : r_dly[SQRT_CELLS-1].ay;
        w_p.angle_z = r_dly[SQRT_CELLS-1].az;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p <= w_p;
        end
        if (w_oload) begin
            r_o <= r_p;
        end
    end

    assign o_euler.valid   = r_o_vld;
    assign o_euler.angle_x = r_o.angle_x;
    assign o_euler.angle_y = r_o.angle_y;
    assign o_euler.angle_z = r_o.angle_z;

    // The two pole bands never overlap.
    `QTE_ASSERT_SAME(a_pole_excl, i_clk, i_rst_n, r_vld[2], !(r_pole[0].pp && r_pole[0].pn))
    // The pipeline stops only when both output-side registers are held.
    `QTE_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, !w_en, r_vld[LAT-1] && r_o_vld && !o_euler.ready)
    // A waiting item stays put until the receiver takes it.
    `QTE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_o_vld && !o_euler.ready, r_o_vld && $stable(r_o))
    // A pole item leaves the output stage with zero roll.
    `QTE_ASSERT_NEXT(a_pole_roll, i_clk, i_rst_n, w_en && r_vld[LAT-2] && (r_pole[POLE_LEN-1].pp || r_pole[POLE_LEN-1].pn), r_p.angle_y == '0)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import qte_pkg::*;

    logic i_clk;
    logic i_rst_n;

    qte_quat_if  quat_ch ();
    qte_euler_if euler_ch ();

    quaternion_to_euler_angles_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch.sink),
        .o_euler (euler_ch.source)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Angles expected from the converter, oldest first.
    t_euler angles_due[$];
    int     n_errors;
    // When set, the receiver refuses items until hold_cycles has counted down to zero.
    bit     hold_request;
    int     hold_cycles;
    bit     rx_quiet;

    // Pipeline depth given for the block; used to let it drain at the end.
    localparam int PIPE_LATENCY = 54;

    // Step table: atan(2^-i) in units of 2^-16 degree.
    localparam longint ATAN_STEP [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0};

    // Arithmetic right shift that rounds toward minus infinity.
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    // Matrix term from 2*FRACTION_BITS fraction bits to the working format with WORK_BITS fraction bits.
    function automatic longint term_scale(input longint v);
        if (2 * FRACTION_BITS >= WORK_BITS)
            return shr_floor(v, 2 * FRACTION_BITS - WORK_BITS);
        return v * (longint'(1) << (WORK_BITS - 2 * FRACTION_BITS));
    endfunction

    // Vectoring-mode rotation; returns the angle in 2^-16 degree units.
    function automatic longint vector_angle(input longint yy, input longint xx);
        longint acc, dx, dy;
        acc = 0;
        if (xx == 0 && yy == 0)
            return 0;
        if (xx < 0) begin
            acc = (yy >= 0) ? 180 * 65536 : -180 * 65536;
            xx  = -xx;
            yy  = -yy;
        end
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            dx = shr_floor(yy, i);
            dy = shr_floor(xx, i);
            if (yy >= 0) begin
                xx += dx;
                yy -= dy;
                acc += ATAN_STEP[i];
            end else begin
                xx -= dx;
                yy += dy;
                acc -= ATAN_STEP[i];
            end
        end
        return acc;
    endfunction

    // Integer square root, floor.
    function automatic longint root_floor(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n  -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // Round half up to 1/128 degree and clamp to +-180 degrees.
    function automatic logic signed [OUT_W-1:0] deg128(input longint a);
        longint r;
        r = shr_floor(a + 256, 9);
        if (r > OUT_LIMIT)
            r = OUT_LIMIT;
        if (r < -OUT_LIMIT)
            r = -OUT_LIMIT;
        return OUT_W'(r);
    endfunction

    function automatic t_euler euler_of(input logic signed [15:0] qw, input logic signed [15:0] qx,
                                        input logic signed [15:0] qy, input logic signed [15:0] qz);
        longint w, x, y, z, one, m00, m01, m10, m11, m20, m21, m22, s, c;
        longint unsigned sq;
        t_euler e;
        w = qw; x = qx; y = qy; z = qz;
        one = longint'(1) << (2 * FRACTION_BITS);
        m00 = term_scale(one - 2 * (y * y + z * z));
        m01 = term_scale(2 * (x * y + w * z));
        m10 = term_scale(2 * (x * y - w * z));
        m11 = term_scale(one - 2 * (x * x + z * z));
        m20 = term_scale(2 * (x * z + w * y));
        m21 = term_scale(2 * (y * z - w * x));
        m22 = term_scale(one - 2 * (x * x + y * y));
        if (m21 >= THR_LO && m21 <= THR_HI) begin
            e.angle_x = OUT_W'(OUT_LIMIT);
            e.angle_y = '0;
            e.angle_z = deg128(vector_angle(m10, m00));
        end else if (m21 >= -THR_HI && m21 <= -THR_LO) begin
            e.angle_x = OUT_W'(-OUT_LIMIT);
            e.angle_y = '0;
            e.angle_z = deg128(vector_angle(m10, m00));
        end else begin
            // The asin argument is saturated to [-1, 1] before the root.
            s = -m21;
            if (s > (longint'(1) << WORK_BITS))
                s = longint'(1) << WORK_BITS;
            if (s < -(longint'(1) << WORK_BITS))
                s = -(longint'(1) << WORK_BITS);
            sq = (s < 0) ? -s : s;
            sq = sq * sq;
            c = root_floor((64'd1 << (2 * WORK_BITS)) - sq);
            e.angle_x = deg128(vector_angle(s, c));
            e.angle_y = deg128(vector_angle(m20, m22));
            e.angle_z = deg128(vector_angle(m01, m11));
        end
        return e;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 70);
    endfunction

    bit gaps_on;

    task automatic send_quat(input logic signed [15:0] qw, input logic signed [15:0] qx,
                             input logic signed [15:0] qy, input logic signed [15:0] qz);
        int g;
        g = gaps_on ? gap_len() : 0;
        // Valid drops only for a real gap, so back-to-back items keep it high.
        if (g > 0) begin
            quat_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        quat_ch.valid <= 1'b1;
        quat_ch.q_w   <= qw;
        quat_ch.q_x   <= qx;
        quat_ch.q_y   <= qy;
        quat_ch.q_z   <= qz;
        angles_due.push_back(euler_of(qw, qx, qy, qz));
        @(posedge i_clk);
        while (!quat_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic drop_valid();
        quat_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (angles_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Receiver: ready toggles at random, is held low on request, or stays high while rx_quiet is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            euler_ch.ready <= 1'b0;
        end else if (hold_request && hold_cycles > 0) begin
            euler_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (rx_quiet) begin
            euler_ch.ready <= 1'b1;
        end else begin
            euler_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // Checks every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_euler want;
        if (i_rst_n && euler_ch.valid && euler_ch.ready) begin
            if (angles_due.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = angles_due.pop_front();
                if (euler_ch.angle_x !== want.angle_x)
                    report_mismatch("angle_x", euler_ch.angle_x, want.angle_x);
                if (euler_ch.angle_y !== want.angle_y)
                    report_mismatch("angle_y", euler_ch.angle_y, want.angle_y);
                if (euler_ch.angle_z !== want.angle_z)
                    report_mismatch("angle_z", euler_ch.angle_z, want.angle_z);
            end
        end
    end

    // Field extremes, identity, poles and the degenerate quaternions.
    task automatic test_directed();
        logic signed [15:0] v [0:4];
        v = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh4000, 16'shC000};
        send_quat(16'sh4000, 0, 0, 0);           // identity
        send_quat(0, 0, 0, 0);                   // zero quaternion: the matrix is that of the identity
        send_quat(16'sh2D41, 16'shD2BF, 0, 0);   // pole, m21 ~ +1: angle_x pinned at +180
        send_quat(16'sh2D41, 16'sh2D41, 0, 0);   // pole, m21 ~ -1: angle_x pinned at -180
        send_quat(16'sh2D41, 16'shD2BF, 16'sh0100, 16'sh0200);
        send_quat(16'sh2000, 16'shE000, 16'sh2000, 16'shE000);
        send_quat(0, 0, 0, 16'sh4000);           // 180 degree yaw, left half plane
        send_quat(0, 0, 16'sh4000, 0);
        send_quat(0, 16'sh4000, 0, 0);
        send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF); // far from unit length
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh7FFF, 16'sh8000, 0, 0);   // asin argument saturates
        send_quat(16'sh8000, 16'sh7FFF, 0, 0);
        for (int i = 0; i < 5; i++)
            send_quat(v[i], v[(i + 1) % 5], v[(i + 2) % 5], v[(i + 3) % 5]);
        drop_valid();
        wait_drained();
    endtask

    // Mostly near-unit quaternions, some raw noise, some near the poles.
    task automatic test_random(input int n);
        real a, b, c, d, nrm;
        logic signed [15:0] qw, qx, qy, qz;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    qw = $urandom; qx = $urandom; qy = $urandom; qz = $urandom;
                end
                2: begin
                    // Near a pole: w = -x or w = x, small y and z.
                    qw = 16'sh2D41 + $signed(16'($urandom_range(0, 400))) - 16'sd200;
                    qx = ($urandom_range(0, 1) ? qw : -qw) + $signed(16'($urandom_range(0, 200)))
                         - 16'sd100;
                    qy = $signed(16'($urandom_range(0, 600))) - 16'sd300;
                    qz = $signed(16'($urandom_range(0, 600))) - 16'sd300;
                end
                default: begin
                    a = $itor($urandom_range(0, 65534)) - 32767.0;
                    b = $itor($urandom_range(0, 65534)) - 32767.0;
                    c = $itor($urandom_range(0, 65534)) - 32767.0;
                    d = $itor($urandom_range(0, 65534)) - 32767.0;
                    nrm = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
                    qw = $rtoi(a / nrm * 16384.0);
                    qx = $rtoi(b / nrm * 16384.0);
                    qy = $rtoi(c / nrm * 16384.0);
                    qz = $rtoi(d / nrm * 16384.0);
                end
            endcase
            send_quat(qw, qx, qy, qz);
        end
        drop_valid();
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering items.
    task automatic test_backpressure();
        hold_cycles  = 150;
        hold_request = 1'b1;
        gaps_on      = 1'b0;
        test_random(120);
        hold_request = 1'b0;
        gaps_on      = 1'b1;
        wait_drained();
    endtask

    // Full rate on both sides.
    task automatic test_streaming();
        rx_quiet = 1'b1;
        gaps_on  = 1'b0;
        test_random(100);
        rx_quiet = 1'b0;
        gaps_on  = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        quat_ch.valid  = 1'b0;
        quat_ch.q_w    = '0;
        quat_ch.q_x    = '0;
        quat_ch.q_y    = '0;
        quat_ch.q_z    = '0;
        n_errors       = 0;
        hold_request   = 1'b0;
        hold_cycles    = 0;
        rx_quiet       = 1'b0;
        gaps_on        = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        wait_drained();
        test_backpressure();
        test_streaming();
        test_random(230);
        wait_drained();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Run limit: far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

FILE: quaternion_to_euler_angles_unit.f
+incdir+hw/rtl
hw/rtl/qte_pkg.sv
hw/rtl/qte_quat_if.sv
hw/rtl/qte_euler_if.sv
hw/rtl/qte_sqrt_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/quaternion_to_euler_angles_unit.sv
tb/tb_top.sv
